FILE: hdl/histogram_equalize_binarize_top_macros.svh
`ifndef HISTOGRAM_EQUALIZE_BINARIZE_TOP_MACROS_SVH
`define HISTOGRAM_EQUALIZE_BINARIZE_TOP_MACROS_SVH

// The enclosing module must have clk_i and rst_ni.
`define HEB_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`define HEB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/heb_pkg.sv
package heb_pkg;

  localparam int BINS       = 256;
  localparam int SMP_W      = 8;
  localparam int CH_W       = 2;
  localparam int OP_W       = 2;
  localparam int PC_W       = 21;
  localparam int TH_W       = 8;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 21;

  localparam logic [CFG_IDX_W-1:0] REG_PIXEL_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD   = 2'd1;

  localparam logic [PC_W-1:0]  PC_RESET  = 21'd145112;
  localparam logic [TH_W-1:0]  TH_RESET  = 8'd127;
  localparam logic [PIX_W-1:0] PIX_WHITE = 8'hFF;
  localparam logic [PIX_W-1:0] PIX_BLACK = 8'h00;

  typedef enum logic [OP_W-1:0] {
    OP_COUNT = 2'd0,
    OP_MAP   = 2'd1,
    OP_CLEAR = 2'd2
  } heb_op_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_CNT_RD,
    S_CNT_WR,
    S_MAP_SUM,
    S_MAP_TAIL,
    S_DIV_INIT,
    S_DIV_SAT,
    S_DIV_STEP,
    S_OUT
  } heb_state_e;

  typedef struct packed {
    logic load_item;
    logic rd_issue;
    logic k_inc;
    logic bin_write;
    logic clr_step;
    logic div_init;
    logic div_sat;
    logic div_step;
    logic out_load;
  } heb_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            ch_ok;
    logic            k_last;
    logic            clr_last;
    logic            step_last;
  } heb_sts_t;

endpackage

FILE: hdl/heb_ctrl.sv
`include "histogram_equalize_binarize_top_macros.svh"

module heb_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  heb_pkg::heb_sts_t sts_i,
  output heb_pkg::heb_cmd_t cmd_o
);
  import heb_pkg::*;

  heb_state_e state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d         = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.op)
          OP_COUNT: state_d = sts_i.ch_ok ? S_CNT_RD : S_IDLE;
          OP_MAP:   state_d = sts_i.ch_ok ? S_MAP_SUM : S_DIV_INIT;
          OP_CLEAR: state_d = S_CLEAR;
          default:  state_d = S_IDLE;
        endcase
      end
      S_CNT_RD: begin
        cmd_o.rd_issue = 1'b1;
        state_d        = S_CNT_WR;
      end
      S_CNT_WR: begin
        cmd_o.bin_write = 1'b1;
        state_d         = S_IDLE;
      end
      S_MAP_SUM: begin
        cmd_o.rd_issue = 1'b1;
        if (sts_i.k_last) begin
          state_d = S_MAP_TAIL;
        end else begin
          cmd_o.k_inc = 1'b1;
        end
      end
      S_MAP_TAIL: begin
        state_d = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV_SAT;
      end
      S_DIV_SAT: begin
        cmd_o.div_sat = 1'b1;
        state_d       = S_DIV_STEP;
      end
      S_DIV_STEP: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.step_last) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = cmd_o.out_load | (out_valid_q & ~out_ready_i);
  assign out_valid_o = out_valid_q;

  `HEB_ASSERT_IMPL(a_no_overwrite, cmd_o.out_load, !out_valid_q || out_ready_i, "Result overwritten before transfer.")
  `HEB_ASSERT_IMPL(a_write_valid_channel, cmd_o.bin_write, sts_i.ch_ok, "Bin written for an invalid channel.")
  `HEB_ASSERT_NEXT(a_div_to_out, state_q == S_DIV_STEP && sts_i.step_last, state_q == S_OUT, "Divider did not finish into the output state.")
  `HEB_ASSERT_IMPL(a_no_accept_busy, in_ready_o, !cmd_o.clr_step && !cmd_o.rd_issue, "Input ready while the histogram is busy.")

endmodule

FILE: hdl/heb_dp.sv
module heb_dp #(
  parameter int CHANNELS   = 3,
  parameter int MAX_PIXELS = 1048576
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  heb_pkg::heb_cmd_t             cmd_i,
  output heb_pkg::heb_sts_t             sts_o,
  input  logic [heb_pkg::OP_W-1:0]      opcode_i,
  input  logic [heb_pkg::CH_W-1:0]      channel_i,
  input  logic [heb_pkg::SMP_W-1:0]     sample_i,
  input  logic                          cfg_valid_i,
  input  logic [heb_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [heb_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output logic [heb_pkg::PIX_W-1:0]     equalized_o,
  output logic [heb_pkg::PIX_W-1:0]     binary_pixel_o
);
  import heb_pkg::*;

  localparam int DEPTH  = CHANNELS * BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int BIN_W  = $clog2(MAX_PIXELS + 1);
  localparam int CUM_W  = BIN_W + SMP_W;
  localparam int NUM_W  = (CUM_W + 10 > PC_W + 9) ? CUM_W + 10 : PC_W + 9;

  logic [PC_W-1:0]  pc_q;
  logic [TH_W-1:0]  th_q;

  logic [OP_W-1:0]  op_q;
  logic [CH_W-1:0]  ch_q;
  logic [SMP_W-1:0] smp_q;
  logic [SMP_W-1:0] k_q;

  logic [BIN_W-1:0] mem_q [DEPTH];
  logic [BIN_W-1:0] rd_data_q;
  logic             rd_vld_q;
  logic [ADDR_W-1:0] raddr, waddr, clr_addr_q;
  logic              mem_we;
  logic [BIN_W-1:0]  wdata, bin_inc;

  logic [CUM_W-1:0] acc_q;
  logic [NUM_W-1:0] rem_q, dsh_q, rem_sub;
  logic             ge;
  logic [PC_W-1:0]  div;
  logic             sat_q;
  logic [PIX_W-1:0] quo_q;
  logic [2:0]       step_q;
  logic [PIX_W-1:0] eq;
  logic [PIX_W-1:0] eq_q, bin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= PC_RESET;
      th_q <= TH_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_PIXEL_COUNT: pc_q <= cfg_data_i[PC_W-1:0];
        REG_THRESHOLD:   th_q <= cfg_data_i[TH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      op_q  <= opcode_i;
      ch_q  <= channel_i;
      smp_q <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      k_q        <= '0;
      clr_addr_q <= '0;
      rd_vld_q   <= 1'b0;
      step_q     <= '0;
    end else begin
      rd_vld_q <= cmd_i.rd_issue;
      if (cmd_i.load_item) begin
        k_q <= (opcode_i == OP_COUNT) ? sample_i : '0;
      end else if (cmd_i.k_inc) begin
        k_q <= k_q + 1'b1;
      end
      if (cmd_i.clr_step) begin
        clr_addr_q <= sts_o.clr_last ? '0 : clr_addr_q + 1'b1;
      end
      if (cmd_i.div_sat) begin
        step_q <= 3'd7;
      end else if (cmd_i.div_step) begin
        step_q <= step_q - 1'b1;
      end
    end
  end

  assign raddr   = ADDR_W'({ch_q, k_q});
  assign bin_inc = (rd_data_q < BIN_W'(MAX_PIXELS)) ? rd_data_q + 1'b1 : rd_data_q;
  assign mem_we  = cmd_i.clr_step | cmd_i.bin_write;
  assign waddr   = cmd_i.clr_step ? clr_addr_q : raddr;
  assign wdata   = cmd_i.clr_step ? '0 : bin_inc;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= wdata;
    end
    if (cmd_i.rd_issue) begin
      rd_data_q <= mem_q[raddr];
    end
  end

  assign div     = (pc_q == '0) ? PC_W'(1) : pc_q;
  assign ge      = rem_q >= dsh_q;
  assign rem_sub = rem_q - dsh_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      acc_q <= '0;
    end else if (rd_vld_q) begin
      acc_q <= acc_q + CUM_W'(rd_data_q);
    end
    if (cmd_i.div_init) begin
      rem_q <= NUM_W'({acc_q, 9'b0}) + NUM_W'(div);
      dsh_q <= NUM_W'({div, 9'b0});
      quo_q <= '0;
    end else if (cmd_i.div_sat) begin
      sat_q <= ge;
      dsh_q <= dsh_q >> 1;
    end else if (cmd_i.div_step) begin
      if (ge) begin
        rem_q <= rem_sub;
      end
      quo_q <= {quo_q[PIX_W-2:0], ge};
      dsh_q <= dsh_q >> 1;
    end
  end

  assign eq = sat_q ? PIX_WHITE : quo_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      eq_q  <= eq;
      bin_q <= (eq > th_q) ? PIX_WHITE : PIX_BLACK;
    end
  end

  assign equalized_o    = eq_q;
  assign binary_pixel_o = bin_q;

  assign sts_o.op        = op_q;
  assign sts_o.ch_ok     = {1'b0, ch_q} < (CH_W + 1)'(CHANNELS);
  assign sts_o.k_last    = k_q == smp_q;
  assign sts_o.clr_last  = clr_addr_q == ADDR_W'(DEPTH - 1);
  assign sts_o.step_last = step_q == '0;

endmodule

FILE: hdl/histogram_equalize_binarize_top.sv
// Count item: once accepted, the dispatch, bin read and bin write states (the last two for
// a valid channel only) run before the next item can be accepted. Map item for sample s:
// a sweep reads bins 0 to s, one memory word per cycle, then the divider resolves one
// quotient bit per cycle; an invalid channel skips the sweep. One item is processed
// at a time. Reset and clear items run a clearing pass over all CHANNELS * 256 bin memory
// words, during which no input item is accepted; configuration writes are always taken.
module histogram_equalize_binarize_top #(
  parameter int CHANNELS   = 3,
  parameter int MAX_PIXELS = 1048576
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  logic [heb_pkg::OP_W-1:0]       opcode_i,
  input  logic [heb_pkg::CH_W-1:0]       channel_i,
  input  logic [heb_pkg::SMP_W-1:0]      sample_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output logic [heb_pkg::PIX_W-1:0]      equalized_o,
  output logic [heb_pkg::PIX_W-1:0]      binary_pixel_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [heb_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [heb_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import heb_pkg::*;

  heb_cmd_t cmd;
  heb_sts_t sts;

  assign cfg_ready_o = 1'b1;

  heb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  heb_dp #(
    .CHANNELS   (CHANNELS),
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .opcode_i       (opcode_i),
    .channel_i      (channel_i),
    .sample_i       (sample_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .equalized_o    (equalized_o),
    .binary_pixel_o (binary_pixel_o)
  );

endmodule

FILE: sim/histogram_equalize_binarize_top_tb.sv
`timescale 1ns / 1ps

module histogram_equalize_binarize_top_tb;
  import heb_pkg::*;

  localparam int NUM_CH          = 3;
  localparam int PIX_MAX         = 1048576;
  localparam int CLK_PERIOD      = 10;
  localparam int SETTLE_CYCLES   = 900;
  localparam int DRAIN_CYCLES    = 300;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int CYCLE_LIMIT     = 3000000;
  localparam int RANDOM_ITEMS    = 720;
  localparam int TAIL_ITEMS      = 60;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;
  localparam logic [OP_W-1:0]      OP_RESERVED = 2'd3;
  localparam logic [CH_W-1:0]      CH_ABSENT   = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [CH_W-1:0]  ch;
    logic [SMP_W-1:0] smp;
  } pixel_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] equalized;
    logic [PIX_W-1:0] binary_pixel;
  } eq_result_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_valid   = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       opcode     = '0;
  logic [CH_W-1:0]       channel    = '0;
  logic [SMP_W-1:0]      sample     = '0;
  logic                  out_valid;
  logic                  out_ready  = 1'b0;
  logic [PIX_W-1:0]      equalized;
  logic [PIX_W-1:0]      binary_pixel;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  logic [PC_W-1:0] bins_q [NUM_CH*BINS];
  logic [PC_W-1:0] pixel_count_q = PC_RESET;
  logic [TH_W-1:0] threshold_q   = TH_RESET;

  eq_result_t  expected_pixels[$];
  pixel_item_t pending_items[$];

  int  issued_cnt    = 0;
  int  accepted_cnt  = 0;
  int  work_cnt      = 0;
  int  error_cnt     = 0;
  int  cycle_cnt     = 0;
  int  hold_off_left = 0;
  bit  idle_on       = 1'b1;

  histogram_equalize_binarize_top dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .opcode_i       (opcode),
    .channel_i      (channel),
    .sample_i       (sample),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .equalized_o    (equalized),
    .binary_pixel_o (binary_pixel),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    foreach (bins_q[i]) bins_q[i] = '0;
  end

  function automatic eq_result_t equalize_bin(logic [CH_W-1:0] ch, logic [SMP_W-1:0] smp);
    longint unsigned cum;
    longint unsigned divisor;
    longint unsigned quo;
    eq_result_t      res;
    cum = 0;
    if (ch < NUM_CH) begin
      for (int k = 0; k <= smp; k++) cum += bins_q[ch * BINS + k];
    end
    divisor = (pixel_count_q == '0) ? 1 : pixel_count_q;
    quo = (cum * 512 + divisor) / (2 * divisor);
    res.equalized    = (quo > 255) ? 8'd255 : quo[7:0];
    res.binary_pixel = (res.equalized > threshold_q) ? PIX_WHITE : PIX_BLACK;
    return res;
  endfunction

  function automatic void apply_pixel_item(pixel_item_t item);
    int slot;
    slot = item.ch * BINS + item.smp;
    case (item.op)
      OP_COUNT: begin
        if (item.ch < NUM_CH && bins_q[slot] < PIX_MAX) bins_q[slot]++;
      end
      OP_MAP: begin
        expected_pixels.push_back(equalize_bin(item.ch, item.smp));
      end
      OP_CLEAR: begin
        foreach (bins_q[i]) bins_q[i] = '0;
      end
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_cnt++;
    $display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  // Each pending item is offered at a falling edge and held until its transfer.
  initial begin : item_driver
    int          gap;
    pixel_item_t item;
    gap = 0;
    forever begin
      @(negedge clk);
      if (gap > 0) begin
        in_valid = 1'b0;
        gap--;
      end else if (pending_items.size() == 0) begin
        in_valid = 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        in_valid = 1'b0;
        gap = $urandom_range(1, 17) - 1;
      end else begin
        item = pending_items.pop_front();
        opcode = item.op;
        channel = item.ch;
        sample = item.smp;
        in_valid = 1'b1;
        do @(posedge clk); while (!in_ready);
        apply_pixel_item(item);
        accepted_cnt++;
      end
    end
  end

  initial begin : result_sink
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_off_left > 0) begin
        out_ready = 1'b0;
        hold_off_left--;
      end else if (stall > 0) begin
        out_ready = 1'b0;
        stall--;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready = 1'b0;
        stall = $urandom_range(1, 17) - 1;
      end else begin
        out_ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    eq_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch("result with no map item waiting", equalized, 0);
      end else begin
        want = expected_pixels.pop_front();
        if (equalized !== want.equalized)
          report_mismatch("equalized", equalized, want.equalized);
        if (binary_pixel !== want.binary_pixel)
          report_mismatch("binary_pixel", binary_pixel, want.binary_pixel);
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_item(logic [OP_W-1:0] op, logic [CH_W-1:0] ch, logic [SMP_W-1:0] smp);
    pixel_item_t item;
    int          ticket;
    item.op = op;
    item.ch = ch;
    item.smp = smp;
    ticket = issued_cnt;
    issued_cnt++;
    if (!(op == OP_RESERVED || (op == OP_COUNT && ch >= NUM_CH))) work_cnt++;
    pending_items.push_back(item);
    wait (accepted_cnt > ticket);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_PIXEL_COUNT: pixel_count_q = data[PC_W-1:0];
      REG_THRESHOLD:   threshold_q = data[TH_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Count and clear items give no result, so the block may still be busy.
  task automatic settle();
    wait (accepted_cnt == issued_cnt && expected_pixels.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic test_directed_items();
    send_item(OP_COUNT, 2'd0, 8'd0);
    send_item(OP_COUNT, 2'd0, 8'd255);
    send_item(OP_COUNT, 2'd1, 8'd128);
    send_item(OP_COUNT, 2'd2, 8'd255);
    send_item(OP_COUNT, 2'd2, 8'd255);
    send_item(OP_COUNT, CH_ABSENT, 8'd9);
    send_item(OP_RESERVED, 2'd0, 8'd0);
    send_item(OP_MAP, 2'd0, 8'd0);
    send_item(OP_MAP, 2'd2, 8'd255);
    settle();
    write_reg(REG_PIXEL_COUNT, 21'd2);
    write_reg(REG_THRESHOLD, 21'd127);
    send_item(OP_MAP, 2'd0, 8'd0);
    send_item(OP_MAP, 2'd0, 8'd255);
    send_item(OP_MAP, 2'd1, 8'd127);
    send_item(OP_MAP, 2'd1, 8'd128);
    send_item(OP_MAP, CH_ABSENT, 8'd255);
    send_item(OP_MAP, 2'd2, 8'd254);
    send_item(OP_MAP, 2'd2, 8'd255);
    send_item(OP_RESERVED, 2'd1, 8'd255);
    send_item(OP_CLEAR, 2'd0, 8'd0);
    send_item(OP_MAP, 2'd0, 8'd255);
    send_item(OP_MAP, 2'd2, 8'd255);
  endtask

  task automatic test_register_extremes();
    send_item(OP_COUNT, 2'd0, 8'd5);
    settle();
    write_reg(REG_PIXEL_COUNT, 21'd0);
    send_item(OP_MAP, 2'd0, 8'd5);
    send_item(OP_MAP, 2'd0, 8'd4);
    settle();
    write_reg(REG_PIXEL_COUNT, 21'h1FFFFF);
    write_reg(REG_THRESHOLD, 21'h1FFF00);
    send_item(OP_MAP, 2'd0, 8'd5);
    settle();
    write_reg(REG_PIXEL_COUNT, 21'd512);
    send_item(OP_MAP, 2'd0, 8'd5);
    settle();
    write_reg(REG_THRESHOLD, 21'h0000FF);
    send_item(OP_MAP, 2'd0, 8'd5);
    settle();
    write_reg(REG_PIXEL_COUNT, 21'd1);
    write_reg(REG_SPARE_A, 21'($urandom));
    write_reg(REG_SPARE_B, 21'($urandom));
    send_item(OP_MAP, 2'd0, 8'd5);
    settle();
    write_reg(REG_PIXEL_COUNT, 21'(PIX_MAX));
    write_reg(REG_THRESHOLD, 21'd0);
    send_item(OP_MAP, 2'd0, 8'd255);
  endtask

  task automatic test_random_frames(int n_items);
    int n_cnt;
    int n_map;
    int centre;
    int spread;
    int v;
    int r;
    logic [TH_W-1:0] th;
    while (work_cnt < n_items) begin
      settle();
      n_cnt = $urandom_range(4, 48);
      r = $urandom_range(0, 9);
      if (r == 0) write_reg(REG_PIXEL_COUNT, 21'($urandom_range(0, 1)));
      else if (r == 1) write_reg(REG_PIXEL_COUNT, 21'($urandom));
      else write_reg(REG_PIXEL_COUNT, 21'($urandom_range(n_cnt / 2 + 1, n_cnt * 2)));
      r = $urandom_range(0, 9);
      th = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom);
      write_reg(REG_THRESHOLD, {13'($urandom), th});
      if ($urandom_range(0, 7) == 0) write_reg(REG_SPARE_A + 2'($urandom_range(0, 1)),
                                               21'($urandom));
      if ($urandom_range(0, 3) != 0) send_item(OP_CLEAR, 2'($urandom), 8'($urandom));
      centre = $urandom_range(0, 255);
      spread = $urandom_range(0, 128);
      repeat (n_cnt) begin
        if ($urandom_range(0, 15) == 0) begin
          send_item(2'($urandom), 2'($urandom), 8'($urandom));
        end else begin
          v = centre + $urandom_range(0, 2 * spread) - spread;
          v = (v < 0) ? 0 : (v > 255) ? 255 : v;
          send_item(OP_COUNT, 2'($urandom_range(0, NUM_CH - 1)), 8'(v));
        end
      end
      n_map = $urandom_range(4, 24);
      repeat (n_map) begin
        if ($urandom_range(0, 15) == 0)
          send_item(2'($urandom), 2'($urandom), 8'($urandom));
        else
          send_item(OP_MAP, 2'($urandom_range(0, NUM_CH - 1)), 8'($urandom));
      end
    end
  endtask

  task automatic test_backpressure();
    settle();
    repeat (6) send_item(OP_COUNT, 2'd1, 8'($urandom_range(0, 40)));
    hold_off_left = HOLD_OFF_CYCLES;
    repeat (8) send_item(OP_MAP, 2'd1, 8'($urandom_range(0, 60)));
  endtask

  task automatic test_quiet_tail();
    idle_on = 1'b0;
    repeat (TAIL_ITEMS) begin
      if ($urandom_range(0, 2) == 0)
        send_item(OP_MAP, 2'($urandom_range(0, NUM_CH - 1)), 8'($urandom));
      else
        send_item(OP_COUNT, 2'($urandom_range(0, NUM_CH - 1)), 8'($urandom));
    end
  endtask

  initial begin : main_sequence
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_items();
    test_register_extremes();
    test_random_frames(RANDOM_ITEMS);
    test_backpressure();
    test_quiet_tail();
    wait (accepted_cnt == issued_cnt && expected_pixels.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hdl
hdl/heb_pkg.sv
hdl/heb_ctrl.sv
hdl/heb_dp.sv
hdl/histogram_equalize_binarize_top.sv
sim/histogram_equalize_binarize_top_tb.sv
